>>> design/array_list_table_engine_defines.svh
// Assertion macros for the ordered list engine.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH
`define ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ALTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define ALTE_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) else $error(msg);

`endif

>>> design/alte_pkg.sv
// Shared types and constants for the ordered list engine.
// No dependencies; imported by the sequencer, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package alte_pkg;

  // Default store geometry.
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Request kinds. Code 7 has no meaning and is handled as a no-op.
  typedef enum logic [2:0] {
    OP_APPEND         = 3'd0,
    OP_INSERT         = 3'd1,
    OP_RM_LAST        = 3'd2,
    OP_RM_FIRST_MATCH = 3'd3,
    OP_RM_LAST_MATCH  = 3'd4,
    OP_CLEAR          = 3'd5,
    OP_SEARCH         = 3'd6
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_BAD_POS   = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_RDLAST,
    S_DONE
  } state_e;

  // One request as it arrives.
  typedef struct packed {
    op_e                req_type;
    logic signed [31:0] item_value;
    logic [6:0]         position;
  } req_t;

  // One result as it leaves.
  typedef struct packed {
    status_e            status;
    logic [5:0]         found_position;
    logic signed [31:0] removed_value;
    logic [6:0]         entry_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/alte_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; width and depth are parameters.
`timescale 1ns / 1ps
`default_nettype none

module alte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/alte_seq.sv
// Request sequencer: decodes a request, walks the entry store through the
// RAM ports (scan, shift up, shift down) and builds the result. Uses alte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alte_seq
  import alte_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW         = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire req_t                   in_data_i,
  input  wire logic                   slot_free_i,
  output logic                        rsp_valid_o,
  output rsp_t                        rsp_data_o,
  output logic                        mem_we_o,
  output logic      [AW-1:0]          mem_waddr_o,
  output logic      [VALUE_WIDTH-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic      [AW-1:0]          mem_raddr_o,
  input  wire logic [VALUE_WIDTH-1:0] mem_rdata_i
);

  localparam int CMPW = (CW > 7) ? CW : 7;

  // Control state.
  state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          pend_q, pend_d;
  logic          hit_vld_q, hit_vld_d;

  // Per-request working registers.
  op_e                    op_q, op_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          pend_idx_q, pend_idx_d;
  logic [AW-1:0]          hit_q, hit_d;
  status_e                stat_q, stat_d;
  logic [AW-1:0]          fpos_q, fpos_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;

  // Shared decode terms.
  logic                   count_zero;
  logic                   is_full;
  logic                   pos_bad;
  logic [CW-1:0]          last_cnt;
  logic [CW-1:0]          idx_m1;
  logic                   idx_lt;
  logic                   shup_more;
  logic                   rd_match;
  logic                   pend_last;
  logic                   scan_first;
  logic                   scan_stop_first;
  logic                   scan_hit_any;
  logic [AW-1:0]          last_hit;
  logic [VALUE_WIDTH-1:0] in_val;

  assign in_val          = VALUE_WIDTH'(in_data_i.item_value);
  assign count_zero      = (count_q == '0);
  assign is_full         = (count_q == CW'(CAPACITY));
  assign pos_bad         = (CMPW'(in_data_i.position) > CMPW'(count_q));
  assign last_cnt        = count_q - CW'(1);
  assign idx_m1          = idx_q - CW'(1);
  assign idx_lt          = (idx_q < count_q);
  assign shup_more       = (idx_q > pos_q);
  assign rd_match        = pend_q && (mem_rdata_i == val_q);
  assign pend_last       = pend_q && (CW'(pend_idx_q) == last_cnt);
  assign scan_first      = (op_q == OP_SEARCH) || (op_q == OP_RM_FIRST_MATCH);
  assign scan_stop_first = scan_first && rd_match;
  assign scan_hit_any    = rd_match || hit_vld_q;
  assign last_hit        = rd_match ? pend_idx_q : hit_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.req_type) inside
            OP_APPEND, OP_INSERT: begin
              if ((in_data_i.req_type == OP_INSERT) && pos_bad) begin
                state_d = S_DONE;
              end else if (is_full) begin
                state_d = S_DONE;
              end else begin
                state_d = S_SHUP;
              end
            end
            OP_RM_LAST: begin
              state_d = count_zero ? S_DONE : S_RDLAST;
            end
            OP_RM_FIRST_MATCH, OP_RM_LAST_MATCH, OP_SEARCH: begin
              state_d = count_zero ? S_DONE : S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_stop_first) begin
          state_d = (op_q == OP_SEARCH) ? S_DONE : S_SHDN;
        end else if (pend_last) begin
          state_d = ((op_q == OP_RM_LAST_MATCH) && scan_hit_any) ? S_SHDN : S_DONE;
        end
      end
      S_SHDN: begin
        if (!idx_lt && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_SHUP: begin
        if (!pend_q && !shup_more) begin
          state_d = S_DONE;
        end
      end
      S_RDLAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    count_d     = count_q;
    pend_d      = 1'b0;
    hit_vld_d   = hit_vld_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    stat_d      = stat_q;
    fpos_d      = fpos_q;
    rem_d       = rem_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.req_type;
          val_d     = in_val;
          idx_d     = '0;
          hit_vld_d = 1'b0;
          stat_d    = STAT_OK;
          fpos_d    = '0;
          rem_d     = '0;
          unique case (in_data_i.req_type) inside
            OP_APPEND, OP_INSERT: begin
              pos_d = (in_data_i.req_type == OP_APPEND) ? count_q
                                                         : CW'(in_data_i.position);
              idx_d = count_q;
              if ((in_data_i.req_type == OP_INSERT) && pos_bad) begin
                stat_d = STAT_BAD_POS;
              end else if (is_full) begin
                stat_d = STAT_FULL;
              end
            end
            OP_RM_LAST: begin
              if (count_zero) begin
                stat_d = STAT_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = last_cnt[AW-1:0];
                fpos_d      = last_cnt[AW-1:0];
              end
            end
            OP_RM_FIRST_MATCH, OP_RM_LAST_MATCH: begin
              if (count_zero) begin
                stat_d = STAT_EMPTY;
              end
            end
            OP_SEARCH: begin
              if (count_zero) begin
                stat_d = STAT_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Read entries in order and compare each against the request value.
      S_SCAN: begin
        if (idx_lt) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          pend_d      = 1'b1;
          pend_idx_d  = idx_q[AW-1:0];
          idx_d       = idx_q + CW'(1);
        end
        if (rd_match && (op_q == OP_RM_LAST_MATCH)) begin
          hit_d     = pend_idx_q;
          hit_vld_d = 1'b1;
        end
        if (scan_stop_first) begin
          fpos_d = pend_idx_q;
          pend_d = 1'b0;
          idx_d  = CW'(pend_idx_q) + CW'(1);
          if (op_q == OP_RM_FIRST_MATCH) begin
            rem_d = val_q;
          end
        end else if (pend_last) begin
          if ((op_q == OP_RM_LAST_MATCH) && scan_hit_any) begin
            fpos_d = last_hit;
            idx_d  = CW'(last_hit) + CW'(1);
            rem_d  = val_q;
            pend_d = 1'b0;
          end else begin
            stat_d = STAT_NOT_FOUND;
          end
        end
      end

      // Move every entry above the removed one down by one place.
      S_SHDN: begin
        if (idx_lt) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          pend_d      = 1'b1;
          pend_idx_d  = idx_q[AW-1:0];
          idx_d       = idx_q + CW'(1);
        end
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_idx_q - AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (!idx_lt && !pend_q) begin
          count_d = count_q - CW'(1);
        end
      end

      // Move entries from the top down to the insert point up by one place,
      // then write the new value into the freed slot.
      S_SHUP: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_idx_q + AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (shup_more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_m1[AW-1:0];
          pend_d      = 1'b1;
          pend_idx_d  = idx_m1[AW-1:0];
          idx_d       = idx_m1;
        end else if (!pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wdata_o = val_q;
          count_d     = count_q + CW'(1);
        end
      end

      // The last entry arrives from the read issued at acceptance.
      S_RDLAST: begin
        rem_d   = mem_rdata_i;
        count_d = count_q - CW'(1);
      end

      S_DONE: begin
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      hit_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      hit_vld_q <= hit_vld_d;
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    stat_q     <= stat_d;
    fpos_q     <= fpos_d;
    rem_q      <= rem_d;
  end

  // Handshake and result.
  assign in_ready_o                = (state_q == S_IDLE);
  assign rsp_valid_o               = (state_q == S_DONE) && slot_free_i;
  assign rsp_data_o.status         = stat_q;
  assign rsp_data_o.found_position = 6'(fpos_q);
  assign rsp_data_o.removed_value  = 32'(signed'(rem_q));
  assign rsp_data_o.entry_count    = 7'(count_q);

endmodule

`default_nettype wire

>>> design/array_list_table_engine.sv
// Ordered list engine. A request is accepted in the idle cycle; scans and shifts
// take one stored entry per cycle through the RAM's single read and write port.
// Clear, rejected requests and the unused code go straight to the result;
// remove-last reads the last entry, a scan reads entries in order, an insert
// shifts the entries from its position up, and a match removal shifts those
// above the removed one down. Throughput: one request at a time, the next is
// accepted in the cycle the previous result becomes valid.
// Reset empties the list at once; stored words stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "array_list_table_engine_defines.svh"

module array_list_table_engine
  import alte_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic slot_free;
  logic rsp_valid;
  rsp_t rsp_data;

  logic out_valid_q, out_valid_d;
  rsp_t out_data_q, out_data_d;

  // Entry store.
  alte_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Request sequencer.
  alte_seq #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .rsp_valid_o (rsp_valid),
    .rsp_data_o  (rsp_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: takes a new result when empty or draining this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (rsp_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = rsp_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the sequencer and store traffic.
  `ALTE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready did not drop after a transfer")
  `ALTE_ASSERT(a_no_write_idle, mem_we |-> !in_ready_o, "store written while idle")
  `ALTE_ASSERT(a_no_rw_collide, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "read and write hit one entry")
  `ALTE_ASSERT(a_full_count, (out_valid_o && (out_data_o.status == STAT_FULL)) |-> (out_data_o.entry_count == 7'(CAPACITY)), "full status with a list that is not full")

endmodule

`default_nettype wire

>>> verif/array_list_table_engine_tb.sv
// Self-checking testbench for the ordered list engine (array_list_table_engine).
// Depends on alte_pkg; a queue-based list predictor checks every response transfer.
`timescale 1ns / 1ps

module array_list_table_engine_tb;
  import alte_pkg::*;

  localparam int LIST_DEPTH        = CAPACITY_DEF;
  localparam int IDLE_MAX          = 13;
  localparam int LONG_STALL_AT     = 150;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES      = 2 * LIST_DEPTH + 20;
  localparam int CYCLE_LIMIT       = 400000;

  // Phases of the random request stream.
  typedef enum int {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN
  } phase_e;

  // One pending request and the idle cycles the sender inserts before it.
  typedef struct {
    req_t        req;
    int unsigned gap;
  } feed_item_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  feed_item_t         request_feed[$];
  rsp_t               awaited_results[$];
  logic signed [31:0] list_q[$];
  logic signed [31:0] value_pool[8];

  int          err_cnt      = 0;
  int unsigned tx_wait      = 0;
  int unsigned rx_wait      = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;

  array_list_table_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Index of the first or last stored entry equal to v, or -1 when none.
  function automatic int find_value(logic signed [31:0] v, bit from_end);
    int hit;
    hit = -1;
    for (int i = 0; i < list_q.size(); i++) begin
      if (list_q[i] == v) begin
        hit = i;
        if (!from_end) break;
      end
    end
    return hit;
  endfunction

  // Applies one request to the shadow list and returns the response it must give.
  function automatic rsp_t predict_list_op(req_t r);
    rsp_t       res;
    int         n;
    int         hit;
    logic [6:0] pos;
    res        = '0;
    res.status = STAT_OK;
    n          = list_q.size();
    case (r.req_type)
      OP_APPEND, OP_INSERT: begin
        pos = (r.req_type == OP_APPEND) ? 7'(n) : r.position;
        // Position is checked before capacity.
        if (pos > n) begin
          res.status = STAT_BAD_POS;
        end else if (n >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          list_q.insert(pos, r.item_value);
        end
      end
      OP_RM_LAST: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.found_position = 6'(n - 1);
          res.removed_value  = list_q.pop_back();
        end
      end
      OP_RM_FIRST_MATCH, OP_RM_LAST_MATCH: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          hit = find_value(r.item_value, r.req_type == OP_RM_LAST_MATCH);
          if (hit < 0) begin
            res.status = STAT_NOT_FOUND;
          end else begin
            res.found_position = 6'(hit);
            res.removed_value  = r.item_value;
            list_q.delete(hit);
          end
        end
      end
      OP_CLEAR: begin
        list_q.delete();
      end
      OP_SEARCH: begin
        hit = find_value(r.item_value, 1'b0);
        if (hit < 0) res.status = STAT_NOT_FOUND;
        else res.found_position = 6'(hit);
      end
      default: begin
        // The unused request code leaves the list alone.
      end
    endcase
    res.entry_count = 7'(list_q.size());
    return res;
  endfunction

  // Queues one request; some stretches of the stream carry no idle cycles.
  task automatic queue_req(op_e op, logic signed [31:0] v, logic [6:0] p);
    feed_item_t it;
    it.req.req_type   = op;
    it.req.item_value = v;
    it.req.position   = p;
    if (((request_feed.size() / 40) % 4) == 3) it.gap = 0;
    else it.gap = $urandom_range(0, IDLE_MAX);
    request_feed.push_back(it);
  endtask

  // Values come mostly from a small pool so that searches and removals hit.
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return value_pool[$urandom_range(0, 7)];
    if (r == 6) return 32'sh8000_0000;
    if (r == 7) return 32'sh7FFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [6:0] pick_position(int unsigned near_max);
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, near_max));
  endfunction

  // Generates one phase of random requests.
  task automatic gen_phase(phase_e ph, int unsigned count);
    int unsigned r;
    op_e         op;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      case (ph)
        PH_FILL: begin
          if (r < 65) op = OP_APPEND;
          else if (r < 85) op = OP_INSERT;
          else if (r < 90) op = OP_SEARCH;
          else if (r < 95) op = OP_RM_FIRST_MATCH;
          else if (r < 98) op = OP_RM_LAST;
          else op = op_e'(3'd7);
          queue_req(op, pick_value(), pick_position(8));
        end
        PH_CHURN: begin
          op = op_e'($urandom_range(0, 7));
          // Keep clears rare so the list stays populated.
          if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_APPEND;
          queue_req(op, pick_value(), pick_position(LIST_DEPTH));
        end
        default: begin
          if (r < 30) op = OP_RM_LAST;
          else if (r < 60) op = OP_RM_FIRST_MATCH;
          else if (r < 90) op = OP_RM_LAST_MATCH;
          else op = OP_SEARCH;
          queue_req(op, pick_value(), pick_position(LIST_DEPTH));
        end
      endcase
    end
  endtask

  task automatic check_field(string name, logic signed [32:0] want_v,
                             logic signed [32:0] got_v);
    if (got_v !== want_v) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Request driver: offers the next queued item after its idle gap.
  always @(posedge clk or negedge rst_n) begin
    logic       nxt_valid;
    req_t       nxt_data;
    feed_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      tx_wait = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      // A request transfer updates the shadow list at once.
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_list_op(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && request_feed.size() != 0) begin
        if (tx_wait < request_feed[0].gap) begin
          tx_wait++;
        end else begin
          it        = request_feed.pop_front();
          nxt_data  = it.req;
          nxt_valid = 1'b1;
          tx_wait   = 0;
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Response monitor: checks each response transfer and paces out_ready.
  always @(posedge clk or negedge rst_n) begin
    rsp_t want;
    logic nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait      = 0;
      results_seen = 0;
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          err_cnt++;
          $display("%0t: response with none pending: status %0d, count %0d",
                   $time, out_data.status, out_data.entry_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("found_position", want.found_position, out_data.found_position);
          check_field("removed_value", want.removed_value, out_data.removed_value);
          check_field("entry_count", want.entry_count, out_data.entry_count);
        end
        // One long hold-off fills the block so that it stalls the requests.
        if (results_seen == LONG_STALL_AT) rx_wait = LONG_STALL_CYCLES;
        else if (((results_seen / 60) % 3) == 1) rx_wait = 0;
        else rx_wait = $urandom_range(0, IDLE_MAX);
        nxt_ready = (rx_wait == 0);
      end else if (!out_ready) begin
        if (rx_wait > 0) rx_wait--;
        nxt_ready = (rx_wait == 0);
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus and end of test.
  initial begin
    value_pool[0] = 0;
    value_pool[1] = -1;
    value_pool[2] = 1;
    for (int i = 3; i < 8; i++) value_pool[i] = $urandom();

    // Directed: empty list, bad positions, single entry, insert at both ends,
    // duplicates, misses and the unused request code.
    queue_req(OP_SEARCH, 5, 0);
    queue_req(OP_RM_LAST, 0, 0);
    queue_req(OP_RM_FIRST_MATCH, 5, 0);
    queue_req(OP_RM_LAST_MATCH, 5, 0);
    queue_req(OP_INSERT, 9, 1);
    queue_req(op_e'(3'd7), -1, 7'd127);
    queue_req(OP_APPEND, 32'sh8000_0000, 0);
    queue_req(OP_RM_LAST, 0, 0);
    queue_req(OP_INSERT, 32'sh7FFF_FFFF, 0);
    queue_req(OP_APPEND, 7, 0);
    queue_req(OP_INSERT, 7, 1);
    queue_req(OP_INSERT, -1, 0);
    queue_req(OP_INSERT, 3, 4);
    queue_req(OP_INSERT, 4, 7'd127);
    queue_req(OP_SEARCH, 7, 0);
    queue_req(OP_SEARCH, 12345, 0);
    queue_req(OP_RM_LAST_MATCH, 7, 0);
    queue_req(OP_RM_FIRST_MATCH, 7, 0);
    queue_req(OP_RM_FIRST_MATCH, 99, 0);
    queue_req(OP_RM_LAST, 0, 0);
    queue_req(op_e'(3'd7), 0, 0);
    queue_req(OP_CLEAR, 0, 0);
    queue_req(OP_SEARCH, -1, 0);

    // Random phases; the fill phases run the list into its full state.
    gen_phase(PH_FILL, 100);
    gen_phase(PH_CHURN, 120);
    gen_phase(PH_DRAIN, 60);
    gen_phase(PH_FILL, 100);
    gen_phase(PH_CHURN, 70);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (request_feed.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
